// ===== rtl/bfit_pkg.sv =====
// Shared types and constants for the Bloom filter insert/test core.
// No dependencies.
package bfit_pkg;

    localparam int MAX_BITS_LOG2_DEF = 20;
    localparam int MIN_BITS_LOG2     = 12;
    localparam int LG_W              = 6;
    localparam int CFG_DATA_W        = 5;
    localparam int CFG_IDX_W         = 2;
    localparam int QUEUE_DEPTH       = 2;

    // low half of the golden-ratio multiplier; positions never use product bits above 31
    localparam logic [31:0] GOLDEN_LO = 32'h7F4A7C15;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] SIZE_LOG2_RST  = 5'd12;
    localparam logic [CFG_DATA_W-1:0] HASH_COUNT_RST = 5'd8;

    localparam logic MODE_TEST = 1'b1;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] size_log2;
        logic [CFG_DATA_W-1:0] hash_count;
    } t_cfg;

    typedef struct packed {
        logic clearing;
        logic res_push;
    } t_back_st;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_back_state;

endpackage

// ===== rtl/bfit_fifo.sv =====
// Small first-in first-out queue of generic width.
// Depends on nothing; depth and width come from the instantiating module.
module bfit_fifo #(
    parameter int W     = 1,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          push_ok;
    logic          pop_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push_ok) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop_ok) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({push_ok, pop_ok})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/bfit_front.sv =====
// Front end: takes a digest request and derives the start position and stride.
// Depends on bfit_pkg; feeds the job queue.
module bfit_front #(
    parameter int PW = bfit_pkg::MAX_BITS_LOG2_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic            i_mode,
    input  logic [31:0]     i_word0,
    input  logic [31:0]     i_word2,
    input  logic [31:0]     i_word4,
    output logic            o_full,
    output logic            o_q_push,
    output logic [2*PW:0]   o_q_data,
    input  logic            i_q_full
);

    logic          r_vld;
    logic          r_mode;
    logic [PW-1:0] r_a;
    logic [PW-1:0] r_w2;
    logic [PW-1:0] r_prod;
    logic [31:0]   prod;
    logic [PW-1:0] stride;

    assign prod     = i_word4 * bfit_pkg::GOLDEN_LO;
    assign stride   = (r_w2 ^ r_prod) | PW'(1);
    assign o_full   = r_vld && i_q_full;
    assign o_q_push = r_vld;
    assign o_q_data = {r_mode, r_a, stride};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_full) begin
            r_vld <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && !o_full) begin
            r_mode <= i_mode;
            r_a    <= i_word0[PW-1:0];
            r_w2   <= i_word2[PW-1:0];
            r_prod <= prod[PW-1:0];
        end
    end

endmodule

// ===== rtl/bfit_back.sv =====
// Back end: clears the bit store after reset, then walks the positions of each job.
// Depends on bfit_pkg; pops the job queue and pushes the result queue.
module bfit_back #(
    parameter int PW = bfit_pkg::MAX_BITS_LOG2_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bfit_pkg::t_cfg              i_cfg,
    input  logic                        i_q_empty,
    input  logic [2*PW:0]               i_q_data,
    output logic                        o_q_pop,
    input  logic                        i_res_full,
    output logic                        o_res_data,
    output bfit_pkg::t_back_st          o_st
);

    bfit_pkg::t_back_state r_state, n_state;

    logic                  r_mem [2**PW];
    logic [PW-1:0]         r_pos, n_pos;
    logic [PW-1:0]         r_step, n_step;
    logic [bfit_pkg::CFG_DATA_W-1:0] r_cnt, n_cnt;
    logic                  r_mode, n_mode;
    logic                  r_all, n_all;
    logic                  r_rd_vld, n_rd_vld;
    logic                  r_rd_q;
    logic                  mem_we;
    logic                  mem_wd;
    logic [PW-1:0]         addr;
    logic [PW-1:0]         mask;
    logic [bfit_pkg::LG_W-1:0] lg_raw;
    logic [bfit_pkg::LG_W-1:0] lg;
    logic                  folded;

    always_comb begin
        lg_raw = bfit_pkg::LG_W'(i_cfg.size_log2);
        if (lg_raw < bfit_pkg::LG_W'(bfit_pkg::MIN_BITS_LOG2)) begin
            lg = bfit_pkg::LG_W'(bfit_pkg::MIN_BITS_LOG2);
        end else if (lg_raw > bfit_pkg::LG_W'(PW)) begin
            lg = bfit_pkg::LG_W'(PW);
        end else begin
            lg = lg_raw;
        end
        for (int j = 0; j < PW; j++) begin
            mask[j] = (bfit_pkg::LG_W'(j) < lg);
        end
    end

    assign folded = r_all && (!r_rd_vld || r_rd_q);

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_step     = r_step;
        n_cnt      = r_cnt;
        n_mode     = r_mode;
        n_all      = folded;
        n_rd_vld   = 1'b0;
        mem_we     = 1'b0;
        mem_wd     = 1'b0;
        addr       = r_pos & mask;
        o_q_pop    = 1'b0;
        o_st       = '0;
        o_res_data = (r_mode == bfit_pkg::MODE_TEST) && folded;
        unique case (r_state)
            bfit_pkg::ST_CLEAR: begin
                o_st.clearing = 1'b1;
                addr          = r_pos;
                mem_we        = 1'b1;
                n_pos         = r_pos + 1'b1;
                if (r_pos == '1) begin
                    n_state = bfit_pkg::ST_IDLE;
                end
            end
            bfit_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_mode  = i_q_data[2*PW];
                    n_pos   = i_q_data[2*PW-1:PW];
                    n_step  = i_q_data[PW-1:0];
                    n_cnt   = i_cfg.hash_count;
                    n_all   = 1'b1;
                    n_state = (i_cfg.hash_count == '0) ? bfit_pkg::ST_DONE
                                                       : bfit_pkg::ST_RUN;
                end
            end
            bfit_pkg::ST_RUN: begin
                if (r_mode == bfit_pkg::MODE_TEST) begin
                    n_rd_vld = 1'b1;
                end else begin
                    mem_we = 1'b1;
                    mem_wd = 1'b1;
                end
                n_pos = r_pos + r_step;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == bfit_pkg::CFG_DATA_W'(1)) begin
                    n_state = bfit_pkg::ST_DONE;
                end
            end
            bfit_pkg::ST_DONE: begin
                if (!i_res_full) begin
                    o_st.res_push = 1'b1;
                    n_state       = bfit_pkg::ST_IDLE;
                end
            end
            default: n_state = bfit_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bfit_pkg::ST_CLEAR;
            r_pos    <= '0;
            r_rd_vld <= 1'b0;
            r_all    <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_rd_vld <= n_rd_vld;
            r_all    <= n_all;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_cnt  <= n_cnt;
        r_mode <= n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[addr] <= mem_wd;
        end
        r_rd_q <= r_mem[addr];
    end

endmodule

// ===== rtl/bloom_filter_insert_test_core.sv =====
// Bloom filter insert/test core: front hash stage, job queue, back bit-store walker.
// A request passes one multiply stage, the queue, a load, one bit-store access per
// position and the result push. The back end takes a new digest only once it is through
// with the last, since the single-port bit store is walked one position at a time.
// Reset: the store is swept to zero, one bit a cycle, with o_full high;
// configuration writes are taken throughout.
module bloom_filter_insert_test_core #(
    parameter int MAX_BITS_LOG2 = bfit_pkg::MAX_BITS_LOG2_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    output logic                               o_full,
    input  logic                               i_mode,
    input  logic [31:0]                        i_digest_word0,
    input  logic [31:0]                        i_digest_word1,
    input  logic [31:0]                        i_digest_word2,
    input  logic [31:0]                        i_digest_word3,
    input  logic [31:0]                        i_digest_word4,
    output logic                               o_empty,
    input  logic                               i_pop,
    output logic                               o_present,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bfit_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bfit_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int PW = MAX_BITS_LOG2;

    bfit_pkg::t_cfg     r_cfg;
    bfit_pkg::t_back_st w_back_st;

    logic          w_front_full;
    logic          w_q_push;
    logic [2*PW:0] w_q_wdata;
    logic          w_q_full;
    logic          w_q_empty;
    logic [2*PW:0] w_q_rdata;
    logic          w_q_pop;
    logic          w_res_data;
    logic          w_res_full;
    logic          w_take;

    // word1 and word3 only reach hash bits above the position width
    assign o_full      = w_front_full || w_back_st.clearing;
    assign w_take      = i_push && !o_full;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size_log2  <= bfit_pkg::SIZE_LOG2_RST;
            r_cfg.hash_count <= bfit_pkg::HASH_COUNT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bfit_pkg::CFG_SIZE_LOG2:  r_cfg.size_log2  <= i_cfg_data;
                bfit_pkg::CFG_HASH_COUNT: r_cfg.hash_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bfit_front #(
        .PW (PW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_take),
        .i_mode   (i_mode),
        .i_word0  (i_digest_word0),
        .i_word2  (i_digest_word2),
        .i_word4  (i_digest_word4),
        .o_full   (w_front_full),
        .o_q_push (w_q_push),
        .o_q_data (w_q_wdata),
        .i_q_full (w_q_full)
    );

    bfit_fifo #(
        .W     (2 * PW + 1),
        .DEPTH (bfit_pkg::QUEUE_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata),
        .o_empty (w_q_empty)
    );

    bfit_back #(
        .PW (PW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_empty  (w_q_empty),
        .i_q_data   (w_q_rdata),
        .o_q_pop    (w_q_pop),
        .i_res_full (w_res_full),
        .o_res_data (w_res_data),
        .o_st       (w_back_st)
    );

    bfit_fifo #(
        .W     (1),
        .DEPTH (bfit_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_back_st.res_push),
        .i_data  (w_res_data),
        .o_full  (w_res_full),
        .i_pop   (i_pop),
        .o_data  (o_present),
        .o_empty (o_empty)
    );

    a_no_take_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) w_back_st.clearing |-> o_full
    ) else $error("request taken during store clear");

    a_res_push_has_room: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) w_back_st.res_push |-> !w_res_full
    ) else $error("result pushed into full queue");

    a_job_push_has_room: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) (w_q_push && !w_front_full) |-> !w_q_full
    ) else $error("job pushed into full queue");

endmodule

// ===== tb/sv/tb_bloom_filter_insert_test_core.sv =====
// Self-checking testbench for bloom_filter_insert_test_core: queued digest requests,
// a bit-accurate filter predictor, randomised push/pop pacing and register retuning.
// Depends on rtl/bfit_pkg.sv and rtl/bloom_filter_insert_test_core.sv.
`timescale 1ns / 100ps

module tb_bloom_filter_insert_test_core;

    localparam int          STORE_LG         = bfit_pkg::MAX_BITS_LOG2_DEF;
    localparam int          STORE_BITS       = 1 << STORE_LG;
    localparam logic [63:0] GOLDEN_RATIO_MUL = 64'h9E3779B97F4A7C15;
    localparam logic        MODE_INSERT      = ~bfit_pkg::MODE_TEST;
    localparam logic [bfit_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [bfit_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam int          SETTLE_CYCLES    = 40;
    localparam int          MAX_PRINTS       = 40;

    typedef logic [4:0][31:0] t_digest;

    typedef struct packed {
        logic    mode;
        t_digest words;
    } t_digest_req;

    logic                            i_clk          = 1'b0;
    logic                            i_rst_n        = 1'b0;
    logic                            i_push         = 1'b0;
    logic                            i_mode         = 1'b0;
    logic [31:0]                     i_digest_word0 = '0;
    logic [31:0]                     i_digest_word1 = '0;
    logic [31:0]                     i_digest_word2 = '0;
    logic [31:0]                     i_digest_word3 = '0;
    logic [31:0]                     i_digest_word4 = '0;
    logic                            i_pop          = 1'b0;
    logic                            i_cfg_valid    = 1'b0;
    logic [bfit_pkg::CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [bfit_pkg::CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                            o_full;
    logic                            o_empty;
    logic                            o_present;
    logic                            o_cfg_ready;

    // predictor state
    bit                              filter_image [0:STORE_BITS-1];
    logic [bfit_pkg::CFG_DATA_W-1:0] model_size_log2  = bfit_pkg::SIZE_LOG2_RST;
    logic [bfit_pkg::CFG_DATA_W-1:0] model_hash_count = bfit_pkg::HASH_COUNT_RST;

    t_digest_req pending_q[$];
    logic        present_expected_q[$];
    t_digest     inserted_q[$];

    logic steady_flow     = 1'b0;
    int   items_queued    = 0;
    int   results_checked = 0;
    int   error_count     = 0;
    int   inserts_done    = 0;
    int   tests_done      = 0;
    int   hits_seen       = 0;
    int   reg_writes      = 0;

    bloom_filter_insert_test_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_mode         (i_mode),
        .i_digest_word0 (i_digest_word0),
        .i_digest_word1 (i_digest_word1),
        .i_digest_word2 (i_digest_word2),
        .i_digest_word3 (i_digest_word3),
        .i_digest_word4 (i_digest_word4),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_present      (o_present),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string msg);
        if (error_count < MAX_PRINTS)
            $display("%0t ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    // Walks the derived positions: marks them for an insert, checks them for a test.
    function automatic logic probe_and_mark(input logic mode, input t_digest w);
        int          lg;
        logic [63:0] mask;
        logic [63:0] base;
        logic [63:0] stride;
        logic [63:0] pos;
        logic        all_set;
        lg = int'(model_size_log2);
        if (lg < bfit_pkg::MIN_BITS_LOG2) lg = bfit_pkg::MIN_BITS_LOG2;
        if (lg > STORE_LG) lg = STORE_LG;
        mask    = (64'd1 << lg) - 64'd1;
        base    = {w[1], w[0]};
        stride  = {w[3], w[2]} ^ (64'(w[4]) * GOLDEN_RATIO_MUL);
        stride[0] = 1'b1;
        all_set = 1'b1;
        for (int k = 0; k < model_hash_count; k++) begin
            pos = (base + 64'(k) * stride) & mask;
            if (mode == bfit_pkg::MODE_TEST) begin
                if (!filter_image[pos[STORE_LG-1:0]]) all_set = 1'b0;
            end else begin
                filter_image[pos[STORE_LG-1:0]] = 1'b1;
            end
        end
        return (mode == bfit_pkg::MODE_TEST) && all_set;
    endfunction

    // request driver
    always @(posedge i_clk) begin : drive_requests
        t_digest_req nxt;
        logic        want;
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else begin
            if (i_push && !o_full) begin
                want = probe_and_mark(i_mode, {i_digest_word4, i_digest_word3,
                                               i_digest_word2, i_digest_word1,
                                               i_digest_word0});
                present_expected_q = {present_expected_q, want};
                if (i_mode == bfit_pkg::MODE_TEST) begin
                    tests_done++;
                    if (want) hits_seen++;
                end else begin
                    inserts_done++;
                end
            end
            if (!i_push || !o_full) begin
                if (pending_q.size() != 0 && (steady_flow || $urandom_range(99) >= 38)) begin
                    nxt = pending_q.pop_front();
                    i_push         <= 1'b1;
                    i_mode         <= nxt.mode;
                    i_digest_word0 <= nxt.words[0];
                    i_digest_word1 <= nxt.words[1];
                    i_digest_word2 <= nxt.words[2];
                    i_digest_word3 <= nxt.words[3];
                    i_digest_word4 <= nxt.words[4];
                end else begin
                    i_push <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : check_results
        logic want;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                if (present_expected_q.size() == 0) begin
                    flag_mismatch("result popped with no request outstanding");
                end else begin
                    want = present_expected_q.pop_front();
                    if (o_present !== want)
                        flag_mismatch($sformatf("present: got %b, expected %b",
                                                o_present, want));
                end
                results_checked++;
            end
            i_pop <= steady_flow || ($urandom_range(99) >= 38);
        end
    end

    task automatic queue_digest(input logic mode, input t_digest w);
        t_digest_req r;
        r.mode  = mode;
        r.words = w;
        pending_q = {pending_q, r};
        items_queued++;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (results_checked != items_queued);
    endtask

    task automatic write_register(input logic [bfit_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [bfit_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == bfit_pkg::CFG_SIZE_LOG2) model_size_log2 = data;
        else if (idx == bfit_pkg::CFG_HASH_COUNT) model_hash_count = data;
        reg_writes++;
    endtask

    task automatic retune(input logic [bfit_pkg::CFG_DATA_W-1:0] size_lg,
                          input logic [bfit_pkg::CFG_DATA_W-1:0] count);
        wait_drained();
        write_register(bfit_pkg::CFG_SIZE_LOG2, size_lg);
        write_register(bfit_pkg::CFG_HASH_COUNT, count);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_digest fresh_digest();
        t_digest d;
        for (int k = 0; k < 5; k++) d[k] = rand_word();
        return d;
    endfunction

    initial begin : stimulus
        t_digest dz, d1, da, db, dc, dd, dg;
        int      roll;
        logic [bfit_pkg::CFG_DATA_W-1:0] sz, hc;
        dz = '0;
        d1 = '1;
        da = fresh_digest();
        db = fresh_digest();
        dc = {5{32'hAAAA_5555}};
        dd = fresh_digest();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default geometry, extreme digests
        queue_digest(MODE_INSERT,         dz);
        queue_digest(bfit_pkg::MODE_TEST, dz);
        queue_digest(bfit_pkg::MODE_TEST, d1);
        queue_digest(MODE_INSERT,         d1);
        queue_digest(bfit_pkg::MODE_TEST, d1);
        dg = d1;
        dg[4] = '0;
        queue_digest(bfit_pkg::MODE_TEST, dg);

        // size below range, zero hash count
        retune(5'd0, 5'd0);
        queue_digest(MODE_INSERT,         da);
        queue_digest(bfit_pkg::MODE_TEST, db);

        // size above range, hash count above sixteen
        retune(5'd31, 5'd31);
        queue_digest(MODE_INSERT,         dc);
        queue_digest(bfit_pkg::MODE_TEST, dc);
        dg = dc;
        dg[2][0] = ~dg[2][0];
        queue_digest(bfit_pkg::MODE_TEST, dg);
        queue_digest(MODE_INSERT,         {5{32'h5555_AAAA}});

        // unused register indexes must not disturb anything
        wait_drained();
        write_register(CFG_SPARE_2, 5'd31);
        write_register(CFG_SPARE_3, 5'd0);
        write_register(bfit_pkg::CFG_HASH_COUNT, 5'd17);
        queue_digest(bfit_pkg::MODE_TEST, dc);
        queue_digest(bfit_pkg::MODE_TEST, {5{32'h5555_AAAA}});

        // shrink the filter over bits set at the largest size
        retune(5'd12, 5'd16);
        queue_digest(bfit_pkg::MODE_TEST, dc);
        queue_digest(MODE_INSERT,         dd);
        queue_digest(bfit_pkg::MODE_TEST, dd);
        queue_digest(bfit_pkg::MODE_TEST, da);

        for (int p = 0; p < 10; p++) begin
            case (p % 4)
                0:       sz = 5'd12;
                1:       sz = 5'd20;
                default: sz = bfit_pkg::CFG_DATA_W'($urandom_range(31));
            endcase
            case (p % 5)
                0:       hc = 5'd1;
                1:       hc = 5'd16;
                2:       hc = 5'd31;
                3:       hc = bfit_pkg::CFG_DATA_W'($urandom_range(12));
                default: hc = 5'd8;
            endcase
            wait_drained();
            steady_flow <= (p == 3);
            if (p == 5) write_register($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3,
                                       bfit_pkg::CFG_DATA_W'($urandom_range(31)));
            write_register(bfit_pkg::CFG_SIZE_LOG2, sz);
            write_register(bfit_pkg::CFG_HASH_COUNT, hc);
            inserted_q.delete();
            for (int n = 0; n < 123; n++) begin
                roll = $urandom_range(99);
                if (roll < 45 || (roll < 75 && inserted_q.size() == 0)) begin
                    dg = fresh_digest();
                    queue_digest(MODE_INSERT, dg);
                    inserted_q = {inserted_q, dg};
                    if (inserted_q.size() > 64) void'(inserted_q.pop_front());
                end else if (roll < 75) begin
                    queue_digest(bfit_pkg::MODE_TEST,
                                 inserted_q[$urandom_range(inserted_q.size() - 1)]);
                end else if (roll < 90 || inserted_q.size() == 0) begin
                    queue_digest(bfit_pkg::MODE_TEST, fresh_digest());
                end else begin
                    dg = inserted_q[$urandom_range(inserted_q.size() - 1)];
                    dg[$urandom_range(4)][$urandom_range(31)] ^= 1'b1;
                    queue_digest(bfit_pkg::MODE_TEST, dg);
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (present_expected_q.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", present_expected_q.size()));
        $display("Covered %0d inserts and %0d membership tests (%0d present) across %0d",
                 inserts_done, tests_done, hits_seen, reg_writes);
        $display("register writes, with clamped sizes and hash counts from 0 to 31.");
        if (error_count == 0) begin
            $display("** bloom_filter_insert_test_core: PASSED **");
        end else begin
            $display("** bloom_filter_insert_test_core: FAILED **");
        end
        $finish;
    end

    // clearing sweep plus all traffic, with a wide margin
    initial begin : watchdog
        #(32_000_000);
        $display("Timed out waiting for the core");
        $display("** bloom_filter_insert_test_core: FAILED **");
        $finish;
    end

endmodule

// ===== bloom_filter_insert_test_core.f =====
rtl/bfit_pkg.sv
rtl/bfit_fifo.sv
rtl/bfit_front.sv
rtl/bfit_back.sv
rtl/bloom_filter_insert_test_core.sv
tb/sv/tb_bloom_filter_insert_test_core.sv
